// File: hdl/pfc_pkg.sv
// shared types, constants and key square helper functions for the playfair cipher
package pfc_pkg;

	localparam int SQUARE_SIDE  = 5;
	localparam int CELL_COUNT   = SQUARE_SIDE * SQUARE_SIDE;
	localparam int LETTER_COUNT = 26;

	typedef logic [4:0] letter_t;
	typedef logic [4:0] place_t;
	typedef logic [2:0] coord_t;

	localparam letter_t LETTER_I = 5'd8;
	localparam letter_t LETTER_J = 5'd9;
	localparam letter_t LETTER_Z = 5'd25;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ENC  = 2'd1,
		OP_DEC  = 2'd2
	} op_t;

	// clamp to z, then fold j onto i
	function automatic letter_t norm_letter(input letter_t l);
		letter_t c;
		c = (l > LETTER_Z) ? LETTER_Z : l;
		if (c == LETTER_J) begin
			c = LETTER_I;
		end
		return c;
	endfunction

	// row of a cell by comparing against row starts
	function automatic coord_t place_row(input place_t p);
		coord_t r;
		r = '0;
		for (int k = 1; k < SQUARE_SIDE; k++) begin
			if (p >= place_t'(k * SQUARE_SIDE)) begin
				r = coord_t'(k);
			end
		end
		return r;
	endfunction

	// column of a cell once its row is known
	function automatic coord_t place_col(input place_t p, input coord_t r);
		place_t base;
		base = place_t'(r * SQUARE_SIDE);
		return coord_t'(p - base);
	endfunction

	// one step forward or back, wrapping around the square side
	function automatic coord_t step_coord(input coord_t c, input logic fwd);
		coord_t n;
		if (fwd) begin
			n = (c == coord_t'(SQUARE_SIDE - 1)) ? '0 : c + 3'd1;
		end else begin
			n = (c == '0) ? coord_t'(SQUARE_SIDE - 1) : c - 3'd1;
		end
		return n;
	endfunction

	// cell index from row and column
	function automatic place_t cell_of(input coord_t r, input coord_t c);
		place_t base;
		base = place_t'(r * SQUARE_SIDE);
		return base + place_t'(c);
	endfunction

endpackage

// File: hdl/playfair_digraph_cipher.sv
// playfair digraph cipher: four stage pipeline over a loaded 5x5 key square
// an accepted item moves through stages 1 to 4; its result is presented from the stage 4 register until taken
// throughput: one item per cycle while the output is not stalled
// a stalled result holds the whole pipeline; reset clears only the stage valid bits
// the key square and its inverse map are undefined until loaded
module playfair_digraph_cipher (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       op,
	input  pfc_pkg::place_t  cell_index,
	input  pfc_pkg::letter_t first_letter,
	input  pfc_pkg::letter_t second_letter,
	output logic             out_valid,
	input  logic             out_stall,
	output pfc_pkg::letter_t first_out,
	output pfc_pkg::letter_t second_out
);
	import pfc_pkg::*;

	// square storage
	place_t  letter_place [LETTER_COUNT];
	letter_t key_square   [CELL_COUNT];

	// pipeline state
	logic    adv;
	logic    keep_in;
	logic    is_load_in;
	logic    vld_s1, vld_s2, vld_s3, vld_s4;
	op_t     op_s1, op_s2, op_s3;
	letter_t a_s1, b_s1;
	place_t  cell_s1, cell_s2, cell_s3;
	letter_t lett_s2, lett_s3;
	place_t  p1_s2, p2_s2;
	place_t  addr1_s3, addr2_s3;
	letter_t first_s4, second_s4;

	// stage 2 coordinate logic
	coord_t  r1, c1, r2, c2;
	coord_t  ar1, ac1, ar2, ac2;
	logic    fwd;

	// global advance: everything moves unless a result is held
	assign adv       = !(vld_s4 && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_s4;
	assign first_out  = first_s4;
	assign second_out = second_s4;

	// bad loads and the unused op drop out here
	assign is_load_in = (op == OP_LOAD);
	assign keep_in = (is_load_in && (cell_index < place_t'(CELL_COUNT))
			&& (first_letter <= LETTER_Z))
		|| (op == OP_ENC) || (op == OP_DEC);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid && keep_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3 && (op_s3 != OP_LOAD);
		end
	end

	// stage 1: capture and normalize letters, a load's letter is kept as given
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= op_t'(op);
			cell_s1 <= cell_index;
			a_s1    <= is_load_in ? first_letter : norm_letter(first_letter);
			b_s1    <= norm_letter(second_letter);
		end
	end

	// stage 2: inverse map lookup, loads update the map in item order
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_s1;
			cell_s2 <= cell_s1;
			lett_s2 <= a_s1;
			p1_s2   <= letter_place[a_s1];
			p2_s2   <= letter_place[b_s1];
			if (vld_s1 && (op_s1 == OP_LOAD)) begin
				letter_place[a_s1] <= cell_s1;
			end
		end
	end

	// digraph rules on row and column
	always_comb begin
		r1  = place_row(p1_s2);
		c1  = place_col(p1_s2, r1);
		r2  = place_row(p2_s2);
		c2  = place_col(p2_s2, r2);
		fwd = (op_s2 == OP_ENC);
		ar1 = r1;
		ac1 = c2;
		ar2 = r2;
		ac2 = c1;
		priority if (r1 == r2) begin
			ac1 = step_coord(c1, fwd);
			ac2 = step_coord(c2, fwd);
		end else if (c1 == c2) begin
			ar1 = step_coord(r1, fwd);
			ar2 = step_coord(r2, fwd);
			ac1 = c1;
			ac2 = c2;
		end else begin
			ac1 = c2;
			ac2 = c1;
		end
	end

	// stage 3: target cell addresses
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3    <= op_s2;
			cell_s3  <= cell_s2;
			lett_s3  <= lett_s2;
			addr1_s3 <= cell_of(ar1, ac1);
			addr2_s3 <= cell_of(ar2, ac2);
		end
	end

	// stage 4: key square read into the output register, loads write the square
	always_ff @(posedge clk) begin
		if (adv) begin
			first_s4  <= key_square[addr1_s3];
			second_s4 <= key_square[addr2_s3];
			if (vld_s3 && (op_s3 == OP_LOAD)) begin
				key_square[cell_s3] <= lett_s3;
			end
		end
	end

`ifndef SYNTHESIS
	a_crypt_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s3 && (op_s3 != OP_LOAD)) |=> out_valid)
		else $error("digraph item lost before output");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s3 && (op_s3 == OP_LOAD)) |=> !out_valid)
		else $error("load item produced a result");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> ($stable(vld_s1) && $stable(vld_s2) && $stable(vld_s3)))
		else $error("pipeline moved while stalled");
`endif

endmodule

// File: tb/playfair_digraph_cipher_check.sv
// checker for the playfair digraph cipher: tracks the key square, predicts and compares results
`timescale 1ns / 1ps

module playfair_digraph_cipher_check (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [1:0]       op,
	input  pfc_pkg::place_t  cell_index,
	input  pfc_pkg::letter_t first_letter,
	input  pfc_pkg::letter_t second_letter,
	input  logic             out_valid,
	input  logic             out_stall,
	input  pfc_pkg::letter_t first_out,
	input  pfc_pkg::letter_t second_out,
	output int               fail_count,
	output int               pending
);
	import pfc_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		letter_t first;
		letter_t second;
	} letter_pair_t;

	// own copy of the square and of the letter to cell map
	letter_t square_cell [CELL_COUNT];
	place_t  letter_cell [LETTER_COUNT];

	letter_pair_t expected_pairs[$];
	int           failures = 0;

	// clamp anything past z, then read j as i
	function automatic int plain_letter(input letter_t l);
		int v;
		v = (l > LETTER_Z) ? int'(LETTER_Z) : int'(l);
		if (v == int'(LETTER_J)) begin
			v = int'(LETTER_I);
		end
		return v;
	endfunction

	// substitute one digraph against the current square
	function automatic letter_pair_t cipher_pair(input logic [1:0] kind, input letter_t a,
			input letter_t b);
		letter_pair_t res;
		int pa, pb, ra, ca, rb, cb, shift;
		pa = int'(letter_cell[plain_letter(a)]);
		pb = int'(letter_cell[plain_letter(b)]);
		ra = pa / SQUARE_SIDE;
		ca = pa % SQUARE_SIDE;
		rb = pb / SQUARE_SIDE;
		cb = pb % SQUARE_SIDE;
		shift = (kind == OP_ENC) ? 1 : SQUARE_SIDE - 1;
		if (ra == rb) begin
			res.first  = square_cell[ra * SQUARE_SIDE + (ca + shift) % SQUARE_SIDE];
			res.second = square_cell[rb * SQUARE_SIDE + (cb + shift) % SQUARE_SIDE];
		end else if (ca == cb) begin
			res.first  = square_cell[((ra + shift) % SQUARE_SIDE) * SQUARE_SIDE + ca];
			res.second = square_cell[((rb + shift) % SQUARE_SIDE) * SQUARE_SIDE + cb];
		end else begin
			res.first  = square_cell[ra * SQUARE_SIDE + cb];
			res.second = square_cell[rb * SQUARE_SIDE + ca];
		end
		return res;
	endfunction

	assign fail_count = failures;

	// compare taken results first, then account for the item taken at this edge
	always @(posedge clk) begin
		letter_pair_t want;
		letter_pair_t got;
		if (!arst_n) begin
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.first  = first_out;
				got.second = second_out;
				if (expected_pairs.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("unexpected result: first %0d second %0d", got.first,
							got.second);
					end
				end else begin
					want = expected_pairs.pop_front();
					if (want.first !== got.first || want.second !== got.second) begin
						failures++;
						if (failures <= REPORT_LIMIT) begin
							$display("mismatch: expected %0d %0d, got %0d %0d", want.first,
								want.second, got.first, got.second);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (op)
					OP_LOAD: begin
						if (cell_index < CELL_COUNT && first_letter <= LETTER_Z) begin
							square_cell[cell_index]   = first_letter;
							letter_cell[first_letter] = cell_index;
						end
					end
					OP_ENC, OP_DEC: begin
						expected_pairs = {expected_pairs,
							cipher_pair(op, first_letter, second_letter)};
					end
					default: begin
					end
				endcase
			end
			pending <= expected_pairs.size();
		end
	end

endmodule

// File: tb/playfair_digraph_cipher_test.sv
// testbench top for the playfair digraph cipher: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module playfair_digraph_cipher_test;
	import pfc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 730;
	localparam int IDLE_PCT      = 17;
	localparam int QUIET_FROM    = 300;
	localparam int QUIET_TO      = 450;
	localparam int HOLD_AT       = 520;
	localparam int HOLD_CYCLES   = 300;
	localparam int PAUSE_AT      = 650;
	localparam int DRAIN_CYCLES  = 10;
	localparam int LIMIT_CYCLES  = 200000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid;
	logic    in_stall;
	logic [1:0] op;
	place_t  cell_index;
	letter_t first_letter;
	letter_t second_letter;
	logic    out_valid;
	logic    out_stall;
	letter_t first_out;
	letter_t second_out;

	int fail_count;
	int pending;
	int sent_count = 0;
	int cycles = 0;
	bit quiet = 1'b0;

	playfair_digraph_cipher i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.cell_index    (cell_index),
		.first_letter  (first_letter),
		.second_letter (second_letter),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.first_out     (first_out),
		.second_out    (second_out)
	);

	playfair_digraph_cipher_check i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.cell_index    (cell_index),
		.first_letter  (first_letter),
		.second_letter (second_letter),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.first_out     (first_out),
		.second_out    (second_out),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// offer one item, with random idle cycles first outside the quiet window, and hold it until taken
	task automatic send_item(input logic [1:0] kind, input place_t target, input letter_t a,
			input letter_t b);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		op            <= kind;
		cell_index    <= target;
		first_letter  <= a;
		second_letter <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sent_count <= sent_count + 1;
	endtask

	// load all 25 cells with the letters other than j, in order or shuffled
	task automatic load_square(input bit shuffle);
		letter_t letters [CELL_COUNT];
		letter_t swap;
		int k, pick;
		for (k = 0; k < CELL_COUNT; k++) begin
			letters[k] = (k < int'(LETTER_J)) ? letter_t'(k) : letter_t'(k + 1);
		end
		if (shuffle) begin
			for (k = CELL_COUNT - 1; k > 0; k--) begin
				pick = $urandom_range(k);
				swap = letters[k];
				letters[k] = letters[pick];
				letters[pick] = swap;
			end
		end
		for (k = 0; k < CELL_COUNT; k++) begin
			send_item(OP_LOAD, place_t'(k), letters[k], letter_t'($urandom_range(31)));
		end
	endtask

	// hold the input idle until every outstanding result has been taken
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// receiver: random stalls, one quiet window and one long hold-off
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sent_count >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (sent_count >= QUIET_FROM && sent_count < QUIET_TO) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// stimulus and verdict
	initial begin
		int n, r;
		letter_t a, b;
		in_valid      <= 1'b0;
		op            <= OP_LOAD;
		cell_index    <= '0;
		first_letter  <= '0;
		second_letter <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// square in alphabet order: rows abcde fghik lmnop qrstu vwxyz
		load_square(1'b0);

		// directed digraphs
		send_item(OP_ENC, 5'd0, 5'd0, 5'd4);            // a e: same row, wraps to column 0
		send_item(OP_DEC, 5'd0, 5'd0, 5'd4);            // a e: same row, wraps to column 4
		send_item(OP_ENC, 5'd0, 5'd0, 5'd21);           // a v: same column, wraps to row 0
		send_item(OP_DEC, 5'd0, 5'd0, 5'd21);           // a v: same column, wraps to row 4
		send_item(OP_ENC, 5'd31, 5'd0, LETTER_Z);       // a z: rectangle corners
		send_item(OP_DEC, 5'd0, LETTER_Z, 5'd0);        // z a: rectangle corners
		send_item(OP_ENC, 5'd0, LETTER_J, 5'd10);       // j read as i, shares a row with k
		send_item(OP_DEC, 5'd0, 5'd3, LETTER_J);        // d with j read as i: same column
		send_item(OP_ENC, 5'd0, 5'd31, 5'd26);          // letters past z read as z z
		send_item(OP_DEC, 5'd0, 5'd1, 5'd1);            // same letter twice shifts along its row
		send_item(OP_ENC, 5'd0, 5'd0, 5'd31);           // a and a letter past z

		// ignored items: unused op and malformed loads
		send_item(OP_UNUSED, 5'd31, 5'd31, 5'd31);
		send_item(OP_LOAD, 5'd25, 5'd3, 5'd0);
		send_item(OP_LOAD, 5'd0, 5'd26, 5'd0);
		send_item(OP_LOAD, 5'd31, 5'd31, 5'd31);
		send_item(OP_ENC, 5'd0, 5'd0, 5'd6);            // square must be unchanged: a g

		// loads at the cell extremes, then a digraph right behind each
		send_item(OP_LOAD, 5'd0, LETTER_J, 5'd31);
		send_item(OP_ENC, 5'd0, 5'd1, 5'd4);            // b e: yields the j now in cell 0
		send_item(OP_LOAD, 5'd24, 5'd0, 5'd0);
		send_item(OP_DEC, 5'd0, 5'd20, 5'd22);          // u w rectangle reaches cell 24

		// random part, with square reshuffles along the way
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= QUIET_FROM && n < QUIET_TO);
			if (n == 0 || n == 250 || n == 700) begin
				load_square(1'b1);
			end
			if (n == PAUSE_AT) begin
				wait_drained();
			end
			r = $urandom_range(99);
			if (r < 78) begin
				a = ($urandom_range(99) < 85) ? letter_t'($urandom_range(25))
				                              : letter_t'($urandom_range(31));
				b = ($urandom_range(99) < 85) ? letter_t'($urandom_range(25))
				                              : letter_t'($urandom_range(31));
				if ($urandom_range(99) < 8) begin
					b = a;
				end
				send_item($urandom_range(1) ? OP_ENC : OP_DEC, place_t'($urandom_range(31)),
					a, b);
			end else if (r < 88) begin
				send_item(OP_LOAD, place_t'($urandom_range(24)), letter_t'($urandom_range(25)),
					letter_t'($urandom_range(31)));
			end else if (r < 95) begin
				send_item(OP_LOAD, place_t'($urandom_range(31)), letter_t'($urandom_range(31)),
					letter_t'($urandom_range(31)));
			end else begin
				send_item(OP_UNUSED, place_t'($urandom_range(31)),
					letter_t'($urandom_range(31)), letter_t'($urandom_range(31)));
			end
		end
		quiet = 1'b0;

		// drain and let the pipeline settle
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/pfc_pkg.sv
hdl/playfair_digraph_cipher.sv
tb/playfair_digraph_cipher_check.sv
tb/playfair_digraph_cipher_test.sv
